// ===== rtl/fwt_pkg.sv =====
// Shared constants for the fast Walsh-Hadamard transform block.
// Used by the channel interfaces and the top level; depends on nothing.

package fwt_pkg;

   localparam int COEF_BITS     = 22;
   localparam int POS_BITS      = 6;
   localparam int LOG2_BITS     = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LOG2_SIZE = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NORMALIZE = 1'd1;

   localparam logic [LOG2_BITS-1:0] LOG2_RESET = 3'd6;

endpackage

// ===== rtl/fwt_if.sv =====
// Valid/ready channel interfaces for sample beats and coefficient beats.
// Depends on fwt_pkg for the coefficient and position widths.

interface fwt_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface fwt_rsp_if import fwt_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [COEF_BITS-1:0] coefficient;
   logic [POS_BITS-1:0]         position;
   logic                        final_res;

   modport source (output valid, output coefficient, output position, output final_res,
                   input ready);
   modport sink   (input valid, input coefficient, input position, input final_res,
                   output ready);
endinterface

// ===== rtl/fwt_ram.sv =====
// Work store: one write port and two registered read ports.
// No dependencies.

module fwt_ram #(
   parameter int ADDR_BITS = 6,
   parameter int WIDTH     = 22
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_BITS-1:0]    wr_addr,
   input  logic signed [WIDTH-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]    rd_addr_a,
   input  logic [ADDR_BITS-1:0]    rd_addr_b,
   output logic signed [WIDTH-1:0] rd_data_a,
   output logic signed [WIDTH-1:0] rd_data_b
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic signed [WIDTH-1:0] mem [DEPTH];
   logic signed [WIDTH-1:0] rd_a_ff;
   logic signed [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/fwt_bfly.sv =====
// Shared radix-2 butterfly: sum and difference of one pair of store entries.
// No dependencies.

module fwt_bfly #(
   parameter int WIDTH = 22
) (
   input  logic signed [WIDTH-1:0] x,
   input  logic signed [WIDTH-1:0] y,
   output logic signed [WIDTH-1:0] sum,
   output logic signed [WIDTH-1:0] diff
);

   // The store is wide enough for the full growth of every stage.
   assign sum  = x + y;
   assign diff = x - y;

endmodule

// ===== rtl/fast_walsh_transform_top.sv =====
// Top level of the fast Walsh-Hadamard transform block: sequencer, register port.
// Depends on fwt_pkg, fwt_if, fwt_ram and fwt_bfly.
//
// Usage: samples arrive as beats on req_bus, one per cycle while req_bus.ready
// is high. Sample i is written to the bit-reversed address of i. When the
// n-th sample (n = 2^log2_size, clamped to 1..log2(MAX_POINTS)) is taken, the
// block drops ready and runs log2_size stages of in-place butterflies through
// one shared add/subtract unit, then sends n coefficient beats on rsp_bus in
// index order, with final_res set on the last one.
// Sequencing: each butterfly writes its two entries one after the other, as
// the store has one write port, and a read state at each stage boundary
// refills the read pipe. Each coefficient then passes through a store read and
// the output register, and waits while rsp_bus stalls. Reset clears the
// sequencer and the load count and sets log2_size to 6 and normalize to 1; the
// store itself is not cleared. A stalled receiver holds the current coefficient
// beat and the sequencer waits. Writing log2_size while loading restarts
// loading from sample zero.

module fast_walsh_transform_top import fwt_pkg::*; #(
   parameter int MAX_POINTS  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   fwt_req_if.sink                  req_bus,
   fwt_rsp_if.source                rsp_bus,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int MAXLOG = $clog2(MAX_POINTS + 1) - 1;
   localparam int WW     = SAMPLE_BITS + MAXLOG;

   typedef enum logic [2:0] {
      S_LOAD, S_BF_RD, S_BF_WA, S_BF_WB, S_OUT_RD, S_OUT_LD
   } state_type;

   state_type                state_ff;
   logic [MAXLOG-1:0]        idx_ff;
   logic [LOG2_BITS-1:0]     stage_ff;
   logic [LOG2_BITS-1:0]     log2_ff;
   logic                     norm_ff;
   logic signed [WW-1:0]     diff_ff;
   logic                     rsp_valid_ff;
   logic signed [COEF_BITS-1:0] coef_ff;
   logic [POS_BITS-1:0]      pos_ff;
   logic                     final_ff;

   logic [LOG2_BITS-1:0]     l_eff;
   logic [MAXLOG-1:0]        n_m1;
   logic [MAXLOG-1:0]        half_m1;
   logic [MAXLOG-1:0]        full_rev;
   logic [MAXLOG-1:0]        load_addr;
   logic [MAXLOG-1:0]        pair_sel;
   logic [MAXLOG-1:0]        a_cur;
   logic [MAXLOG-1:0]        e_cur;
   logic [MAXLOG-1:0]        a_rd;
   logic [MAXLOG-1:0]        e_rd;
   logic                     req_take;
   logic                     out_take;

   logic                     wr_en;
   logic [MAXLOG-1:0]        wr_addr;
   logic signed [WW-1:0]     wr_data;
   logic [MAXLOG-1:0]        rd_addr_a;
   logic [MAXLOG-1:0]        rd_addr_b;
   logic signed [WW-1:0]     rd_data_a;
   logic signed [WW-1:0]     rd_data_b;
   logic signed [WW-1:0]     bf_sum;
   logic signed [WW-1:0]     bf_diff;
   logic signed [WW-1:0]     shifted;

   // Lower address of butterfly pair p at stage s: a zero bit is inserted at bit s.
   function automatic logic [MAXLOG-1:0] pair_low(input logic [MAXLOG-1:0] p,
                                                  input logic [LOG2_BITS-1:0] s);
      logic [MAXLOG-1:0] lo_mask;
      lo_mask  = ~({MAXLOG{1'b1}} << s);
      pair_low = ((((p >> s) << s) << 1) | (p & lo_mask));
   endfunction

   always_comb begin
      l_eff = log2_ff;
      if (log2_ff == '0) begin
         l_eff = LOG2_BITS'(1);
      end else if (log2_ff > LOG2_BITS'(MAXLOG)) begin
         l_eff = LOG2_BITS'(MAXLOG);
      end
   end

   assign n_m1    = {MAXLOG{1'b1}} >> (LOG2_BITS'(MAXLOG) - l_eff);
   assign half_m1 = n_m1 >> 1;

   always_comb begin
      for (int j = 0; j < MAXLOG; j++) begin
         full_rev[j] = idx_ff[MAXLOG-1-j];
      end
   end

   assign load_addr = full_rev >> (LOG2_BITS'(MAXLOG) - l_eff);

   // While the last write of a pair goes out, the next pair is already read.
   assign pair_sel = (state_ff == S_BF_WB) ? idx_ff + MAXLOG'(1) : idx_ff;
   assign a_cur    = pair_low(idx_ff, stage_ff);
   assign e_cur    = a_cur | (MAXLOG'(1) << stage_ff);
   assign a_rd     = pair_low(pair_sel, stage_ff);
   assign e_rd     = a_rd | (MAXLOG'(1) << stage_ff);

   assign req_take = req_bus.valid && (state_ff == S_LOAD);
   assign out_take = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = load_addr;
      wr_data   = WW'(req_bus.sample);
      rd_addr_a = a_rd;
      rd_addr_b = e_rd;
      unique case (state_ff)
         S_LOAD: begin
            wr_en = req_take;
         end
         S_BF_WA: begin
            wr_en   = 1'b1;
            wr_addr = a_cur;
            wr_data = bf_sum;
         end
         S_BF_WB: begin
            wr_en   = 1'b1;
            wr_addr = e_cur;
            wr_data = diff_ff;
         end
         S_OUT_RD, S_OUT_LD: begin
            rd_addr_a = idx_ff;
         end
         default: begin
         end
      endcase
   end

   assign shifted = norm_ff ? (rd_data_a >>> l_eff) : rd_data_a;

   fwt_ram #(
      .ADDR_BITS (MAXLOG),
      .WIDTH     (WW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   fwt_bfly #(
      .WIDTH (WW)
   ) u_bfly (
      .x    (rd_data_a),
      .y    (rd_data_b),
      .sum  (bf_sum),
      .diff (bf_diff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         idx_ff       <= '0;
         stage_ff     <= '0;
         log2_ff      <= LOG2_RESET;
         norm_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LOG2_SIZE: log2_ff <= csr_wdata[LOG2_BITS-1:0];
               CSR_NORMALIZE: norm_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end

         // In S_OUT_LD an accepted beat is replaced by the next one below.
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != S_OUT_LD)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_LOAD: begin
               if (csr_wr_en && (csr_index == CSR_LOG2_SIZE)) begin
                  idx_ff <= '0;
               end else if (req_take) begin
                  if (idx_ff == n_m1) begin
                     idx_ff   <= '0;
                     stage_ff <= '0;
                     state_ff <= S_BF_RD;
                  end else begin
                     idx_ff <= idx_ff + MAXLOG'(1);
                  end
               end
            end
            S_BF_RD: begin
               state_ff <= S_BF_WA;
            end
            S_BF_WA: begin
               diff_ff  <= bf_diff;
               state_ff <= S_BF_WB;
            end
            S_BF_WB: begin
               if (idx_ff == half_m1) begin
                  idx_ff <= '0;
                  if (stage_ff == l_eff - LOG2_BITS'(1)) begin
                     state_ff <= S_OUT_RD;
                  end else begin
                     stage_ff <= stage_ff + LOG2_BITS'(1);
                     state_ff <= S_BF_RD;
                  end
               end else begin
                  idx_ff   <= idx_ff + MAXLOG'(1);
                  state_ff <= S_BF_WA;
               end
            end
            S_OUT_RD: begin
               state_ff <= S_OUT_LD;
            end
            S_OUT_LD: begin
               if (out_take) begin
                  rsp_valid_ff <= 1'b1;
                  coef_ff      <= COEF_BITS'(shifted);
                  pos_ff       <= POS_BITS'(idx_ff);
                  final_ff     <= (idx_ff == n_m1);
                  if (idx_ff == n_m1) begin
                     idx_ff   <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     idx_ff   <= idx_ff + MAXLOG'(1);
                     state_ff <= S_OUT_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign req_bus.ready       = (state_ff == S_LOAD);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.coefficient = coef_ff;
   assign rsp_bus.position    = pos_ff;
   assign rsp_bus.final_res   = final_ff;

`ifndef SYNTHESIS
   a_stage_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BF_RD || state_ff == S_BF_WA || state_ff == S_BF_WB)
      |-> (stage_ff < l_eff))
      else $error("butterfly stage beyond transform length");

   a_pair_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BF_RD || state_ff == S_BF_WA || state_ff == S_BF_WB)
      |-> (idx_ff <= half_m1))
      else $error("butterfly pair index beyond half length");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD || state_ff == S_OUT_RD || state_ff == S_OUT_LD)
      |-> (idx_ff <= n_m1))
      else $error("sample or coefficient index beyond transform length");

   a_final_reopens: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT_LD && out_take && idx_ff == n_m1)
      |=> (rsp_bus.valid && rsp_bus.final_res && req_bus.ready))
      else $error("last coefficient did not reopen loading");
`endif

endmodule

// ===== bench/tb_fast_walsh_transform_top.sv =====
// Self-checking bench for fast_walsh_transform_top: random sample beats against a local
// Walsh-Hadamard predictor, with sizes and modes changed between transforms.
// Depends on fwt_pkg, the fwt_req_if/fwt_rsp_if channels and the block itself.

module tb_fast_walsh_transform_top;
   import fwt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_STALL     = 1500;
   localparam int MAX_LOG2       = 6;
   localparam int RANDOM_ITEMS   = 300;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] coefficient;
      logic [POS_BITS-1:0]         position;
      logic                        final_res;
   } coef_beat_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   fwt_req_if #(.SAMPLE_BITS(16)) req_bus ();
   fwt_rsp_if                     rsp_bus ();

   fast_walsh_transform_top #(
      .MAX_POINTS (64),
      .SAMPLE_BITS(16)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor state, mirroring the block's registers and working store.
   longint            fwt_store [64];
   int unsigned       fill_count = 0;
   logic [2:0]        size_reg   = LOG2_RESET;
   logic              norm_reg   = 1'b1;

   logic signed [15:0] sample_queue [$];
   coef_beat_type      coef_queue [$];

   int unsigned fail_count       = 0;
   bit          no_idle          = 1'b0;
   bit          long_stall_req   = 1'b0;
   bit          long_stall_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned active_log2();
      int unsigned lg;
      lg = size_reg;
      if (lg < 1) lg = 1;
      if (lg > MAX_LOG2) lg = MAX_LOG2;
      return lg;
   endfunction

   // Stores one sample at its bit-reversed slot; the last sample of a load runs the
   // butterflies and queues every coefficient of the transform.
   function automatic void walsh_absorb_sample(input logic signed [15:0] s);
      int unsigned   lg, points, slot, span, blk, a, k, b;
      longint        x, y, v;
      coef_beat_type beat;
      lg = active_log2();
      points = 1 << lg;
      if (fill_count >= points) fill_count = 0;
      slot = 0;
      for (b = 0; b < lg; b++) slot = (slot << 1) | ((fill_count >> b) & 1);
      fwt_store[slot] = longint'(s);
      fill_count++;
      if (fill_count < points) return;
      fill_count = 0;
      for (span = 1; span < points; span = span << 1) begin
         for (blk = 0; blk < points; blk += 2 * span) begin
            for (a = blk; a < blk + span; a++) begin
               x = fwt_store[a];
               y = fwt_store[a + span];
               fwt_store[a]        = x + y;
               fwt_store[a + span] = x - y;
            end
         end
      end
      for (k = 0; k < points; k++) begin
         v = fwt_store[k];
         // Arithmetic shift on a 64-bit value rounds toward minus infinity.
         if (norm_reg) v = v >>> lg;
         beat.coefficient = v[COEF_BITS-1:0];
         beat.position    = k[POS_BITS-1:0];
         beat.final_res   = (k == points - 1);
         coef_queue.push_back(beat);
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Sample driver: valid stays up until the beat is taken.
   always @(posedge clock) begin : sample_driver
      int unsigned tx_gap;
      bit          offering;
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.sample <= '0;
         tx_gap = 0;
      end else begin
         offering = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            walsh_absorb_sample(req_bus.sample);
            void'(sample_queue.pop_front());
            tx_gap = no_idle ? 0 : pick_gap();
            offering = 1'b0;
         end
         if (offering) begin
            req_bus.valid <= 1'b1;
         end else if (tx_gap > 0) begin
            tx_gap--;
            req_bus.valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_bus.valid  <= 1'b1;
            req_bus.sample <= sample_queue[0];
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Coefficient monitor and receiver back-pressure.
   always @(posedge clock) begin : coef_monitor
      int unsigned   rx_hold;
      coef_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (coef_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected coefficient beat: coef %0d pos %0d final %0b",
                           $signed(rsp_bus.coefficient), rsp_bus.position,
                           rsp_bus.final_res);
            end else begin
               want = coef_queue.pop_front();
               if (rsp_bus.coefficient !== want.coefficient ||
                   rsp_bus.position !== want.position ||
                   rsp_bus.final_res !== want.final_res) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: want %0d/%0d/%0b got %0d/%0d/%0b",
                              $signed(want.coefficient), want.position, want.final_res,
                              $signed(rsp_bus.coefficient), rsp_bus.position,
                              rsp_bus.final_res);
               end
            end
         end
         if (long_stall_req && !long_stall_taken) begin
            rx_hold = LONG_STALL;
            long_stall_taken = 1'b1;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rx_hold = no_idle ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int unsigned quiet_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_fast_walsh_transform_top: FAIL");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_LOG2_SIZE) begin
         size_reg   = data;
         fill_count = 0;
      end else if (idx == CSR_NORMALIZE) begin
         norm_reg = data[0];
      end
   endtask

   task automatic settle();
      while (sample_queue.size() != 0 || coef_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Waits for the block to drain, writes normalize (and log2_size if touch_size), then
   // returns at a falling edge so the caller can queue samples without racing the driver.
   task automatic configure(input logic [2:0] size_val, input logic norm_val,
                            input bit touch_size);
      settle();
      if (touch_size) csr_write(CSR_LOG2_SIZE, size_val);
      csr_write(CSR_NORMALIZE, {2'b00, norm_val});
      @(negedge clock);
      no_idle = ($urandom_range(0, 3) == 0);
   endtask

   initial begin : stimulus
      int unsigned queued_total, points, count, i;
      logic [2:0]  size_pick;

      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Size zero behaves as two points; full-scale samples of both signs.
      configure(3'd0, 1'b1, 1'b1);
      sample_queue.push_back(16'sh7fff);
      sample_queue.push_back(16'sh8000);

      // Inverse form with every sample at the negative limit.
      configure(3'd2, 1'b0, 1'b1);
      for (i = 0; i < 4; i++) sample_queue.push_back(16'sh8000);

      // Forward form where the shift has to round negative sums down.
      configure(3'd3, 1'b1, 1'b1);
      sample_queue.push_back(16'sh7fff);
      sample_queue.push_back(16'sh8000);
      sample_queue.push_back(-16'sd1);
      sample_queue.push_back(16'sd1);
      sample_queue.push_back(16'sd0);
      sample_queue.push_back(16'sh7fff);
      sample_queue.push_back(16'sh8000);
      sample_queue.push_back(-16'sd3);

      configure(3'd1, 1'b0, 1'b1);
      sample_queue.push_back(16'sh7fff);
      sample_queue.push_back(16'sh7fff);

      // Size seven saturates to 64 points; the partial load is then abandoned by the
      // size write of the next phase.
      configure(3'd7, 1'b1, 1'b1);
      for (i = 0; i < 3; i++) sample_queue.push_back(pick_sample());

      // Two full 64-point loads against a long receiver stall, so the block must hold
      // off its input while it waits to send.
      configure(3'd6, 1'b0, 1'b1);
      long_stall_req = 1'b1;
      for (i = 0; i < 64; i++) sample_queue.push_back(16'sh8000);
      for (i = 0; i < 64; i++) sample_queue.push_back(pick_sample());
      queued_total = 147;

      while (queued_total < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) size_pick = 3'($urandom_range(0, 4));
         else size_pick = 3'($urandom_range(5, 7));
         configure(size_pick, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
         points = 1 << active_log2();
         count = (points >= 32) ? points : points * $urandom_range(1, 3);
         if ($urandom_range(0, 5) == 0) count += $urandom_range(1, points - 1);
         for (i = 0; i < count; i++) sample_queue.push_back(pick_sample());
         queued_total += count;
      end

      settle();
      if (fail_count == 0 && coef_queue.size() == 0) begin
         $display("tb_fast_walsh_transform_top: PASS");
      end else begin
         if (coef_queue.size() != 0)
            $display("%0d expected coefficient beats never arrived", coef_queue.size());
         $display("tb_fast_walsh_transform_top: FAIL");
      end
      $finish;
   end

endmodule
